@@ hw/rtl/mvs_pkg.sv @@
// ----------------------------------------------------------------------------
// mvs_pkg
// Shared types, command codes and default sizes of the MRU victim selector.
// ----------------------------------------------------------------------------
package mvs_pkg;

  localparam int NUM_SETS_DEF    = 64;
  localparam int NUM_WAYS_DEF    = 8;
  localparam int STAMP_WIDTH_DEF = 32;

  localparam logic [1:0] CMD_TOUCH      = 2'd0;
  localparam logic [1:0] CMD_INVALIDATE = 2'd1;
  localparam logic [1:0] CMD_VICTIM     = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] set_index;
    logic [2:0] way_index;
    logic [7:0] upper_mask;
  } req_t;

  typedef struct packed {
    logic [2:0] victim_way;
    logic       victim_invalid;
  } rsp_t;

endpackage

@@ hw/rtl/mvs_ram.sv @@
// ----------------------------------------------------------------------------
// mvs_ram
// Single-port synchronous RAM with registered read data (read before write).
// ----------------------------------------------------------------------------
module mvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    rdata <= mem[addr];
    if (we) begin
      mem[addr] <= wdata;
    end
  end

endmodule

@@ hw/rtl/mru_victim_selector.sv @@
// ----------------------------------------------------------------------------
// mru_victim_selector
// Most-recently-used way selection for a set-associative cache.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each set's row of
// per-way touch stamps lives in one single-port RAM. A touch or invalidate
// reads the row and writes it back. A victim request reads the row and then
// scans it one way per cycle, and the result appears with done high for
// exactly one cycle right after the scan; the receiver cannot stall it, so
// sample result whenever done is high. A request with an unused command, or
// a touch or invalidate with an out-of-range way, is taken and dropped.
// After reset the block clears the RAM one set per cycle and holds busy high
// until every set is cleared; cfg_write is honored at any time.
// ----------------------------------------------------------------------------
module mru_victim_selector #(
  parameter int NUM_SETS    = mvs_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS    = mvs_pkg::NUM_WAYS_DEF,
  parameter int STAMP_WIDTH = mvs_pkg::STAMP_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  mvs_pkg::req_t request,
  output logic          done,
  output mvs_pkg::rsp_t result,
  input  logic          cfg_write,
  input  logic          cfg_data
);

  localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int ROW_W = NUM_WAYS * STAMP_WIDTH;
  localparam logic [STAMP_WIDTH-1:0] STAMP_MAX = '1;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_MODIFY = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;

  typedef logic [NUM_WAYS-1:0][STAMP_WIDTH-1:0] row_t;

  logic [2:0]             state;
  logic [2:0]             state_next;
  logic [SET_W-1:0]       clr_idx;
  logic                   mode;
  logic [STAMP_WIDTH-1:0] counter;
  mvs_pkg::req_t          req;
  logic [SET_W-1:0]       req_set;
  logic [WAY_W-1:0]       scan;

  logic                   inv_found;
  logic [WAY_W-1:0]       inv_way;
  logic                   all_found;
  logic [STAMP_WIDTH-1:0] all_best;
  logic [WAY_W-1:0]       all_way;
  logic                   free_found;
  logic [STAMP_WIDTH-1:0] free_best;
  logic [WAY_W-1:0]       free_way;

  logic                   inv_found_next;
  logic [WAY_W-1:0]       inv_way_next;
  logic                   all_found_next;
  logic [STAMP_WIDTH-1:0] all_best_next;
  logic [WAY_W-1:0]       all_way_next;
  logic                   free_found_next;
  logic [STAMP_WIDTH-1:0] free_best_next;
  logic [WAY_W-1:0]       free_way_next;

  logic [SET_W-1:0]       set_tab [64];
  logic [SET_W-1:0]       in_set;
  logic [5:0]             in_way_wide;
  logic                   in_way_ok;
  logic                   accept;

  logic                   ram_we;
  logic [SET_W-1:0]       ram_addr;
  logic [ROW_W-1:0]       ram_wdata;
  logic [ROW_W-1:0]       ram_rdata;
  row_t                   rd_row;
  row_t                   wr_row;

  logic [STAMP_WIDTH-1:0] counter_next;
  logic [5:0]             req_way_wide;
  logic [STAMP_WIDTH-1:0] cur_stamp;
  logic [5:0]             scan_wide;
  logic                   upper_hit;
  logic                   scan_last;
  logic [WAY_W-1:0]       pick_way;
  logic [5:0]             pick_wide;

  // Set index reduced modulo NUM_SETS through a constant table.
  for (genvar i = 0; i < 64; i++) begin : g_set_tab
    assign set_tab[i] = SET_W'(i % NUM_SETS);
  end

  assign in_set      = set_tab[request.set_index];
  assign in_way_wide = {3'b000, request.way_index};
  assign in_way_ok   = in_way_wide < 6'(NUM_WAYS);
  assign busy        = (state != ST_IDLE);
  assign accept      = start && !busy;

  assign rd_row       = row_t'(ram_rdata);
  assign req_way_wide = {3'b000, req.way_index};
  assign counter_next = (counter != STAMP_MAX) ? counter + 1'b1 : counter;

  always_comb begin
    wr_row = rd_row;
    if (req.cmd == mvs_pkg::CMD_TOUCH) begin
      wr_row[req_way_wide[WAY_W-1:0]] = counter_next;
    end else begin
      wr_row[req_way_wide[WAY_W-1:0]] = '0;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = req_set;
    ram_wdata = ROW_W'(wr_row);
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_idx;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        ram_addr = in_set;
      end
      ST_MODIFY: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  mvs_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Scan one way per cycle; strict compares keep the lowest index on ties.
  assign cur_stamp = rd_row[scan];
  assign scan_wide = 6'(scan);
  assign upper_hit = (scan_wide < 6'd8) && req.upper_mask[scan_wide[2:0]];
  assign scan_last = (scan == WAY_W'(NUM_WAYS - 1));

  always_comb begin
    inv_found_next  = inv_found;
    inv_way_next    = inv_way;
    all_found_next  = all_found;
    all_best_next   = all_best;
    all_way_next    = all_way;
    free_found_next = free_found;
    free_best_next  = free_best;
    free_way_next   = free_way;
    if (cur_stamp == '0 && !inv_found) begin
      inv_found_next = 1'b1;
      inv_way_next   = scan;
    end
    if (!all_found || cur_stamp > all_best) begin
      all_found_next = 1'b1;
      all_best_next  = cur_stamp;
      all_way_next   = scan;
    end
    if (!upper_hit && (!free_found || cur_stamp > free_best)) begin
      free_found_next = 1'b1;
      free_best_next  = cur_stamp;
      free_way_next   = scan;
    end
  end

  always_comb begin
    if (inv_found_next) begin
      pick_way = inv_way_next;
    end else if (mode && free_found_next) begin
      pick_way = free_way_next;
    end else begin
      pick_way = all_way_next;
    end
  end
  assign pick_wide = 6'(pick_way);

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_idx == SET_W'(NUM_SETS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (request.cmd == mvs_pkg::CMD_VICTIM) begin
            state_next = ST_SCAN;
          end else if ((request.cmd == mvs_pkg::CMD_TOUCH ||
                        request.cmd == mvs_pkg::CMD_INVALIDATE) && in_way_ok) begin
            state_next = ST_MODIFY;
          end
        end
      end
      ST_MODIFY: begin
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_last) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      mode    <= 1'b0;
      counter <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (cfg_write) begin
        mode <= cfg_data;
      end
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (state == ST_MODIFY && req.cmd == mvs_pkg::CMD_TOUCH) begin
        counter <= counter_next;
      end
      if (state == ST_SCAN && scan_last) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req        <= request;
      req_set    <= in_set;
      scan       <= '0;
      inv_found  <= 1'b0;
      all_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (state == ST_SCAN) begin
      scan       <= scan + 1'b1;
      inv_found  <= inv_found_next;
      inv_way    <= inv_way_next;
      all_found  <= all_found_next;
      all_best   <= all_best_next;
      all_way    <= all_way_next;
      free_found <= free_found_next;
      free_best  <= free_best_next;
      free_way   <= free_way_next;
      if (scan_last) begin
        result.victim_way     <= pick_wide[2:0];
        result.victim_invalid <= inv_found_next;
      end
    end
  end

endmodule
